### rtl/core/event_stream_deframer_macros.svh
// Assertion macros for the event stream deframer.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef EVENT_STREAM_DEFRAMER_MACROS_SVH
`define EVENT_STREAM_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define ESD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ESD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ESD_ASSERT_IMP(lbl, ante, cons, msg)
`define ESD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/esd_pkg.sv
// Types and character constants for the event stream deframer.
// No dependencies.
package esd_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        KIND_NAME_RESTART = 3'd0,
        KIND_NAME_BYTE    = 3'd1,
        KIND_DATA_BYTE    = 3'd2,
        KIND_DISPATCH     = 3'd3,
        KIND_DISCARD      = 3'd4
    } esd_kind_t;

    typedef enum logic [1:0] {
        PHASE_FIELD       = 2'd0,
        PHASE_EVENT_VALUE = 2'd1,
        PHASE_DATA_VALUE  = 2'd2,
        PHASE_SKIP        = 2'd3
    } esd_phase_t;

    typedef struct packed {
        esd_phase_t  phase;
        logic        line_is_empty;
        logic [2:0]  match_pos;
        logic        could_event;
        logic        could_data;
        logic        value_at_start;
        logic        cr_held;
        logic        event_has_data;
    } esd_state_t;

    typedef struct packed {
        esd_kind_t   kind;
        logic [7:0]  data;
    } esd_entry_t;

    typedef struct packed {
        logic        vld;
        esd_entry_t  ent;
    } esd_result_t;

    typedef struct packed {
        esd_state_t  st;
        esd_result_t res;
    } esd_step_t;

endpackage

### rtl/core/esd_parse.sv
// Combinational line parser: one input byte against the parser state.
// Gives the next state and up to two results. Depends on esd_pkg.
module esd_parse (
    input  esd_pkg::esd_state_t  st,
    input  logic [7:0]           in_byte,
    output esd_pkg::esd_state_t  st_next,
    output esd_pkg::esd_result_t res0,
    output esd_pkg::esd_result_t res1
);
    import esd_pkg::*;

    localparam esd_result_t NO_RES = '{vld: 1'b0, ent: '{kind: KIND_NAME_RESTART, data: 8'h00}};

    function automatic logic [7:0] event_char(logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h76;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] data_char(logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic esd_step_t line_byte(esd_state_t s, logic [7:0] c);
        esd_step_t r;
        logic      ce;
        logic      cd;
        r.st = s;
        r.res = NO_RES;
        r.st.line_is_empty = 1'b0;
        unique case (s.phase)
            PHASE_FIELD:
            begin
                if (c == CH_COLON)
                begin
                    if (s.line_is_empty)
                    begin
                        r.st.phase = PHASE_SKIP;
                    end
                    else if (s.could_event && s.match_pos == 3'd5)
                    begin
                        r.res = '{vld: 1'b1, ent: '{kind: KIND_NAME_RESTART, data: 8'h00}};
                        r.st.phase = PHASE_EVENT_VALUE;
                        r.st.value_at_start = 1'b1;
                    end
                    else if (s.could_data && s.match_pos == 3'd4)
                    begin
                        if (s.event_has_data)
                        begin
                            r.res = '{vld: 1'b1, ent: '{kind: KIND_DATA_BYTE, data: CH_LF}};
                        end
                        r.st.event_has_data = 1'b1;
                        r.st.phase = PHASE_DATA_VALUE;
                        r.st.value_at_start = 1'b1;
                    end
                    else
                    begin
                        r.st.phase = PHASE_SKIP;
                    end
                end
                else
                begin
                    ce = s.could_event && (s.match_pos < 3'd5) && (event_char(s.match_pos) == c);
                    cd = s.could_data && (s.match_pos < 3'd4) && (data_char(s.match_pos) == c);
                    r.st.could_event = ce;
                    r.st.could_data = cd;
                    if (ce || cd)
                    begin
                        r.st.match_pos = s.match_pos + 3'd1;
                    end
                    else
                    begin
                        r.st.phase = PHASE_SKIP;
                    end
                end
            end
            PHASE_EVENT_VALUE, PHASE_DATA_VALUE:
            begin
                r.st.value_at_start = 1'b0;
                if (!(s.value_at_start && c == CH_SPACE))
                begin
                    r.res.vld = 1'b1;
                    r.res.ent.kind = (s.phase == PHASE_EVENT_VALUE) ? KIND_NAME_BYTE
                                                                    : KIND_DATA_BYTE;
                    r.res.ent.data = c;
                end
            end
            PHASE_SKIP:
            begin
                r.st.phase = PHASE_SKIP;
            end
        endcase
        return r;
    endfunction

    function automatic esd_step_t line_end(esd_state_t s);
        esd_step_t r;
        r.st = s;
        r.res = NO_RES;
        if (s.line_is_empty)
        begin
            r.res.vld = 1'b1;
            r.res.ent.kind = s.event_has_data ? KIND_DISPATCH : KIND_DISCARD;
            r.st.event_has_data = 1'b0;
        end
        else if (s.phase == PHASE_FIELD)
        begin
            if (s.could_event && s.match_pos == 3'd5)
            begin
                r.res = '{vld: 1'b1, ent: '{kind: KIND_NAME_RESTART, data: 8'h00}};
            end
            else if (s.could_data && s.match_pos == 3'd4)
            begin
                if (s.event_has_data)
                begin
                    r.res = '{vld: 1'b1, ent: '{kind: KIND_DATA_BYTE, data: CH_LF}};
                end
                r.st.event_has_data = 1'b1;
            end
        end
        r.st.phase = PHASE_FIELD;
        r.st.line_is_empty = 1'b1;
        r.st.match_pos = 3'd0;
        r.st.could_event = 1'b1;
        r.st.could_data = 1'b1;
        r.st.value_at_start = 1'b0;
        r.st.cr_held = 1'b0;
        return r;
    endfunction

    esd_step_t  step_a;
    esd_step_t  step_b;
    esd_state_t st_mid;

    always_comb
    begin
        step_a = '{st: st, res: NO_RES};
        step_b = '{st: st, res: NO_RES};
        st_mid = st;
        res0 = NO_RES;
        res1 = NO_RES;
        if (in_byte == CH_LF)
        begin
            step_a = line_end(st);
            st_next = step_a.st;
            res0 = step_a.res;
        end
        else
        begin
            // release a held CR as an ordinary line byte
            if (st.cr_held)
            begin
                st_mid.cr_held = 1'b0;
                step_a = line_byte(st_mid, CH_CR);
                st_mid = step_a.st;
                res0 = step_a.res;
            end
            if (in_byte == CH_CR)
            begin
                st_mid.cr_held = 1'b1;
                st_next = st_mid;
            end
            else
            begin
                step_b = line_byte(st_mid, in_byte);
                st_next = step_b.st;
                res1 = step_b.res;
            end
        end
    end

endmodule

### rtl/core/event_stream_deframer.sv
// Event stream deframer top level: parser state, parser and a three-entry result queue.
// Depends on esd_pkg, esd_parse and event_stream_deframer_macros.svh.
//
// Takes one byte of event-stream text per cycle and returns tagged name bytes, data bytes
// and dispatch or discard marks. A byte goes through the parser in the cycle it is
// accepted and its results land in a three-entry output queue, so the first result can
// be taken in the next cycle. Most bytes give zero or one result and the block sustains
// one byte per cycle while in_stall is low; a byte that releases a held CR can give two
// results, which can leave two or more entries queued and raise in_stall until the consumer
// drains them. in_stall is set only by the queue fill level, never by out_stall directly.
`include "event_stream_deframer_macros.svh"

module event_stream_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte
);
    import esd_pkg::*;

    localparam esd_state_t ST_RESET = '{
        phase:          PHASE_FIELD,
        line_is_empty:  1'b1,
        match_pos:      3'd0,
        could_event:    1'b1,
        could_data:     1'b1,
        value_at_start: 1'b0,
        cr_held:        1'b0,
        event_has_data: 1'b0
    };

    esd_state_t  state_reg;
    esd_state_t  state_next;
    esd_state_t  parse_st;
    esd_result_t res0;
    esd_result_t res1;

    esd_entry_t  q_reg [0:2];
    esd_entry_t  q_next [0:2];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    logic        in_acc;
    logic        pop;
    logic [1:0]  push_n;
    logic [1:0]  base;
    esd_entry_t  push_first;

    esd_parse u_parse (
        .st      (state_reg),
        .in_byte (in_byte),
        .st_next (parse_st),
        .res0    (res0),
        .res1    (res1)
    );

    assign in_stall  = (cnt_reg >= 2'd2);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_kind  = q_reg[0].kind;
    assign out_byte  = q_reg[0].data;

    assign push_n     = in_acc ? ({1'b0, res0.vld} + {1'b0, res1.vld}) : 2'd0;
    assign push_first = res0.vld ? res0.ent : res1.ent;
    assign base       = cnt_reg - {1'b0, pop};

    always_comb
    begin
        state_next = in_acc ? parse_st : state_reg;
    end

    always_comb
    begin
        // advance the queue on a pop, then append behind the remaining entries
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            q_next[2] = q_reg[2];
        end
        else
        begin
            q_next[0] = q_reg[0];
            q_next[1] = q_reg[1];
            q_next[2] = q_reg[2];
        end
        if (push_n != 2'd0)
        begin
            q_next[base] = push_first;
        end
        if (push_n == 2'd2)
        begin
            q_next[2'(base + 2'd1)] = res1.ent;
        end
        cnt_next = base + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    `ESD_ASSERT_IMP(a_tag_byte_zero, out_valid && out_kind != KIND_NAME_BYTE && out_kind != KIND_DATA_BYTE, out_byte == 8'h00, "non-byte result carries a nonzero byte")
    `ESD_ASSERT_IMP(a_two_need_cr, push_n == 2'd2, state_reg.cr_held, "two results without a held CR")
    `ESD_ASSERT_NXT(a_lf_clears_cr, in_acc && in_byte == CH_LF, !state_reg.cr_held, "CR still held after LF")
    `ESD_ASSERT_NXT(a_drain_last, pop && cnt_reg == 2'd1 && !in_acc, !out_valid, "queue not empty after last pop")

endmodule

### verif/esd_token_monitor.sv
// Token monitor for the event stream deframer: watches the byte and token channels,
// predicts the tokens of every accepted byte and compares them in order.
// Depends on esd_pkg.
module esd_token_monitor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] out_kind,
    input  logic [7:0] out_byte,
    output int         mismatches,
    output int         tokens_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam logic [0:4][7:0] EVENT_WORD = "event";
    localparam logic [0:3][7:0] DATA_WORD  = "data";

    esd_phase_t  phase;
    logic        empty_line;
    logic [2:0]  match_pos;
    logic        maybe_event;
    logic        maybe_data;
    logic        at_value_start;
    logic        cr_held;
    logic        data_seen;

    esd_entry_t  due_tokens[$];

    task automatic post(input esd_kind_t kind, input logic [7:0] value);
        esd_entry_t tok;
        tok.kind = kind;
        tok.data = value;
        due_tokens.insert(due_tokens.size(), tok);
    endtask

    task automatic clear_line();
        phase          = PHASE_FIELD;
        empty_line     = 1'b1;
        match_pos      = 3'd0;
        maybe_event    = 1'b1;
        maybe_data     = 1'b1;
        at_value_start = 1'b0;
    endtask

    function automatic logic named_event();
        return maybe_event && match_pos == 3'd5;
    endfunction

    function automatic logic named_data();
        return maybe_data && match_pos == 3'd4;
    endfunction

    task automatic open_data();
        if (data_seen)
            post(KIND_DATA_BYTE, CH_LF);
        data_seen = 1'b1;
    endtask

    task automatic take_line_byte(input logic [7:0] c);
        logic first;
        first      = empty_line;
        empty_line = 1'b0;
        case (phase)
            PHASE_FIELD:
            begin
                if (c == CH_COLON)
                begin
                    if (first)
                        phase = PHASE_SKIP;
                    else if (named_event())
                    begin
                        post(KIND_NAME_RESTART, 8'h00);
                        phase          = PHASE_EVENT_VALUE;
                        at_value_start = 1'b1;
                    end
                    else if (named_data())
                    begin
                        open_data();
                        phase          = PHASE_DATA_VALUE;
                        at_value_start = 1'b1;
                    end
                    else
                        phase = PHASE_SKIP;
                end
                else
                begin
                    if (maybe_event && !(match_pos < 3'd5 && EVENT_WORD[match_pos] == c))
                        maybe_event = 1'b0;
                    if (maybe_data && !(match_pos < 3'd4 && DATA_WORD[match_pos] == c))
                        maybe_data = 1'b0;
                    if (maybe_event || maybe_data)
                        match_pos = match_pos + 3'd1;
                    else
                        phase = PHASE_SKIP;
                end
            end
            PHASE_EVENT_VALUE, PHASE_DATA_VALUE:
            begin
                if (at_value_start && c == CH_SPACE)
                    at_value_start = 1'b0;
                else
                begin
                    at_value_start = 1'b0;
                    if (phase == PHASE_EVENT_VALUE)
                        post(KIND_NAME_BYTE, c);
                    else
                        post(KIND_DATA_BYTE, c);
                end
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] c);
        if (c == CH_LF)
        begin
            cr_held = 1'b0;
            if (empty_line)
            begin
                if (data_seen)
                    post(KIND_DISPATCH, 8'h00);
                else
                    post(KIND_DISCARD, 8'h00);
                data_seen = 1'b0;
            end
            else if (phase == PHASE_FIELD)
            begin
                if (named_event())
                    post(KIND_NAME_RESTART, 8'h00);
                else if (named_data())
                    open_data();
            end
            clear_line();
        end
        else
        begin
            if (cr_held)
            begin
                cr_held = 1'b0;
                take_line_byte(CH_CR);
            end
            if (c == CH_CR)
                cr_held = 1'b1;
            else
                take_line_byte(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        esd_entry_t want;
        if (!rst_n)
        begin
            clear_line();
            cr_held   = 1'b0;
            data_seen = 1'b0;
            due_tokens.delete();
            mismatches = 0;
            tokens_due = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token: expected none, got kind %0d byte %02h",
                             $time, out_kind, out_byte);
                    mismatches++;
                end
                else
                begin
                    want = due_tokens.pop_front();
                    if (want.kind !== out_kind)
                    begin
                        $display("%0t: out_kind mismatch: expected %0d, got %0d",
                                 $time, want.kind, out_kind);
                        mismatches++;
                    end
                    if (want.data !== out_byte)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, out_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                parse_byte(in_byte);
            tokens_due = due_tokens.size();
        end
    end

endmodule

### verif/tb_event_stream_deframer.sv
// Top of the event stream deframer testbench: clock, reset, byte requests and token stalls.
// Sends directed lines, then random event-stream text; verdict comes from esd_token_monitor.
// Depends on esd_pkg, esd_token_monitor and event_stream_deframer.
module tb_event_stream_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1500;
    localparam int IDLE_LIMIT   = 2000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    int         mismatches;
    int         tokens_due;

    logic [7:0] byte_stream[$];
    bit         calm = 1'b0;
    int         idle_cycles = 0;

    event_stream_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte)
    );

    esd_token_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .mismatches (mismatches),
        .tokens_due (tokens_due)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int pause_cycles();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic append_byte(input logic [7:0] b);
        byte_stream.insert(byte_stream.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    task automatic add_line_end();
        int r;
        r = $urandom_range(0, 9);
        if (r >= 6)
            append_byte(esd_pkg::CH_CR);
        if (r == 9)
            append_byte(esd_pkg::CH_CR);
        append_byte(esd_pkg::CH_LF);
    endtask

    function automatic logic [7:0] value_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 60)
            b = 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 70)
            b = esd_pkg::CH_COLON;
        else if (r < 80)
            b = esd_pkg::CH_SPACE;
        else if (r < 85)
            b = esd_pkg::CH_CR;
        else
        begin
            b = 8'($urandom_range(0, 255));
            if (b == esd_pkg::CH_LF)
                b = 8'h00;
        end
        return b;
    endfunction

    task automatic add_value();
        int r;
        r = $urandom_range(0, 2);
        append_byte(esd_pkg::CH_COLON);
        repeat (r)
            append_byte(esd_pkg::CH_SPACE);
        repeat ($urandom_range(0, 6))
            append_byte(value_byte());
    endtask

    task automatic add_line();
        int    r;
        string name;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            add_text("data");
            add_value();
        end
        else if (r < 55)
        begin
            add_text("event");
            add_value();
        end
        else if (r < 63)
            add_value();
        else if (r < 73)
        begin
            case ($urandom_range(0, 7))
                0: name = "id";
                1: name = "retry";
                2: name = "eve";
                3: name = "dat";
                4: name = "datas";
                5: name = "events";
                6: name = "Data";
                default: name = "x";
            endcase
            add_text(name);
            if ($urandom_range(0, 1))
                add_value();
        end
        else if (r < 80)
        begin
            if ($urandom_range(0, 1))
                add_text("data");
            else
                add_text("event");
        end
        else if (r < 86)
        begin
            repeat ($urandom_range(1, 8))
                append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                append_byte(value_byte());
            add_value();
        end
        add_line_end();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = pause_cycles();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int gap;
        add_text("\n:c\nevent:");
        append_byte(8'hFF);
        add_text("\r\ndata:a\rb\n\n");
        append_byte(8'h00);
        add_text("\n");
        while (byte_stream.size() < RANDOM_BYTES + 25)
        begin
            repeat ($urandom_range(0, 4))
                add_line();
            add_line_end();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < byte_stream.size(); i++)
        begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = pause_cycles();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= byte_stream[i];
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        while (tokens_due != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### event_stream_deframer.f
+incdir+rtl/core
rtl/core/esd_pkg.sv
rtl/core/esd_parse.sv
rtl/core/event_stream_deframer.sv
verif/esd_token_monitor.sv
verif/tb_event_stream_deframer.sv
